// ===== rtl/lfuc_pkg.sv =====
// Shared types and constants for the LFU cache table.
`default_nettype none
package lfuc_pkg;
  localparam int MaxEntries = 16;
  localparam int KeyBits = 32;
  localparam int DataBits = 32;
  localparam int CountBits = 32;
  localparam int CapBits = 5;
  localparam int FieldBits = 32;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request
    logic search;  // evaluate match and victim, register results
    logic commit;  // apply the update
  } lfuc_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/lfuc_ctrl.sv =====
// Controller: sequences load, search, commit and result delivery.
`default_nettype none
module lfuc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lfuc_pkg::lfuc_cmd_t     cmd
);
  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_COMMIT, S_OUT} state_t;
  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  always_comb begin
    cmd.load   = in_valid && (state == S_IDLE);
    cmd.search = (state == S_SEARCH);
    cmd.commit = (state == S_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_SEARCH;
        S_SEARCH: state <= S_COMMIT;
        S_COMMIT: state <= S_OUT;
        S_OUT:    if (out_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.search, cmd.commit})) else $error("cmd overlap");
  a_commit_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("commit without result");
  a_load_then_search: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.search) else $error("load not followed by search");
endmodule
`default_nettype wire

// ===== rtl/lfuc_datapath.sv =====
// Datapath: entry array, key match, victim choice and update.
`default_nettype none
module lfuc_datapath #(
  parameter int MAX_ENTRIES = lfuc_pkg::MaxEntries,
  parameter int KEY_BITS    = lfuc_pkg::KeyBits,
  parameter int DATA_BITS   = lfuc_pkg::DataBits,
  parameter int COUNT_BITS  = lfuc_pkg::CountBits
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire lfuc_pkg::lfuc_cmd_t                cmd,
  input  wire logic [lfuc_pkg::CapBits-1:0]       capacity,
  input  wire logic                               in_cmd,
  input  wire logic [lfuc_pkg::FieldBits-1:0]     in_key,
  input  wire logic [lfuc_pkg::FieldBits-1:0]     in_value,
  output logic                                    hit,
  output logic [lfuc_pkg::FieldBits-1:0]          read_value,
  output logic                                    evicted,
  output logic [lfuc_pkg::FieldBits-1:0]          evicted_key
);
  localparam int IdxBits = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RecBits = IdxBits;
  localparam int OccBits = $clog2(MAX_ENTRIES + 1);
  localparam int FB = lfuc_pkg::FieldBits;
  localparam int Leaves = 1 << IdxBits;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [MAX_ENTRIES-1:0]  entry_valid;
  logic [KEY_BITS-1:0]     entry_key     [MAX_ENTRIES];
  logic [DATA_BITS-1:0]    entry_data    [MAX_ENTRIES];
  logic [COUNT_BITS-1:0]   entry_uses    [MAX_ENTRIES];
  logic [RecBits-1:0]      entry_recency [MAX_ENTRIES];
  logic [OccBits-1:0]      occupancy;

  logic                    req_put;
  logic [KEY_BITS-1:0]     req_key;
  logic [DATA_BITS-1:0]    req_data;

  // search results, registered
  logic                    found;
  logic [IdxBits-1:0]      found_idx;
  logic                    have_free;
  logic [IdxBits-1:0]      free_idx;
  logic                    have_vic;
  logic [IdxBits-1:0]      vic_idx;
  logic                    full;
  logic [OccBits-1:0]      limit;

  always_comb begin
    if (capacity > lfuc_pkg::CapBits'(MAX_ENTRIES) && MAX_ENTRIES < 32)
      limit = OccBits'(MAX_ENTRIES);
    else
      limit = OccBits'(capacity);
  end

  // per-entry match and first free slot, lowest index wins
  logic                    m_found;
  logic [IdxBits-1:0]      m_found_idx;
  logic                    m_free;
  logic [IdxBits-1:0]      m_free_idx;
  logic                    m_vic;
  logic [IdxBits-1:0]      m_vic_idx;

  always_comb begin
    m_found = 1'b0; m_found_idx = '0;
    m_free = 1'b0;  m_free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == req_key) begin
        m_found = 1'b1; m_found_idx = IdxBits'(i);
      end
      if (!entry_valid[i]) begin
        m_free = 1'b1; m_free_idx = IdxBits'(i);
      end
    end
  end

  // victim: oldest among the lowest counts; recency ranks are unique among valid entries
  // winner tree, one compare per level, registered at the end of search
  logic                    t_ok   [1:2*Leaves-1];
  logic [COUNT_BITS-1:0]   t_uses [1:2*Leaves-1];
  logic [RecBits-1:0]      t_rec  [1:2*Leaves-1];
  logic [IdxBits-1:0]      t_idx  [1:2*Leaves-1];

  always_comb begin
    logic take_left;
    for (int i = 0; i < Leaves; i++) begin
      if (i < MAX_ENTRIES) begin
        t_ok[Leaves+i]   = entry_valid[i];
        t_uses[Leaves+i] = entry_uses[i];
        t_rec[Leaves+i]  = entry_recency[i];
      end else begin
        t_ok[Leaves+i]   = 1'b0;
        t_uses[Leaves+i] = '0;
        t_rec[Leaves+i]  = '0;
      end
      t_idx[Leaves+i] = IdxBits'(i);
    end
    for (int n = Leaves - 1; n >= 1; n--) begin
      take_left = t_ok[2*n] &&
                  (!t_ok[2*n+1] || t_uses[2*n] < t_uses[2*n+1] ||
                   (t_uses[2*n] == t_uses[2*n+1] && t_rec[2*n] >= t_rec[2*n+1]));
      t_ok[n]   = t_ok[2*n] || t_ok[2*n+1];
      t_uses[n] = take_left ? t_uses[2*n] : t_uses[2*n+1];
      t_rec[n]  = take_left ? t_rec[2*n]  : t_rec[2*n+1];
      t_idx[n]  = take_left ? t_idx[2*n]  : t_idx[2*n+1];
    end
    m_vic     = t_ok[1];
    m_vic_idx = t_idx[1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_put  <= (in_cmd == lfuc_pkg::CMD_PUT);
      req_key  <= in_key[KEY_BITS-1:0];
      req_data <= in_value[DATA_BITS-1:0];
    end
    if (cmd.search) begin
      found     <= m_found;
      found_idx <= m_found_idx;
      have_free <= m_free;
      free_idx  <= m_free_idx;
      have_vic  <= m_vic;
      vic_idx   <= m_vic_idx;
      full      <= (occupancy >= limit);
    end
  end

  logic               do_evict;
  logic               do_insert;
  logic [IdxBits-1:0] ins_idx;
  logic               do_bump;

  always_comb begin
    do_bump   = found && (!req_put || limit != '0);
    do_evict  = req_put && limit != '0 && !found && full && have_vic;
    do_insert = req_put && limit != '0 && !found && (do_evict || have_free);
    ins_idx   = do_evict ? vic_idx : free_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
    end else if (cmd.commit) begin
      if (do_insert) begin
        entry_valid[ins_idx] <= 1'b1;
        if (!do_evict) occupancy <= occupancy + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= found;
      read_value  <= (found && !req_put) ?
                     FB'($signed(entry_data[found_idx])) : '1;
      evicted     <= do_evict;
      evicted_key <= do_evict ? FB'($signed(entry_key[vic_idx])) : '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (do_bump) begin
          if (IdxBits'(i) == found_idx) begin
            entry_recency[i] <= '0;
            if (entry_uses[i] != CountMax) entry_uses[i] <= entry_uses[i] + 1'b1;
            if (req_put) entry_data[i] <= req_data;
          end else if (entry_valid[i] && entry_recency[i] < entry_recency[found_idx]) begin
            entry_recency[i] <= entry_recency[i] + 1'b1;
          end
        end else if (do_insert) begin
          if (IdxBits'(i) == ins_idx) begin
            entry_key[i]     <= req_key;
            entry_data[i]    <= req_data;
            entry_uses[i]    <= COUNT_BITS'(1);
            entry_recency[i] <= '0;
          end else if (entry_valid[i]) begin
            // all others age by one; on eviction, those older than the victim keep rank
            if (!do_evict || entry_recency[i] < entry_recency[vic_idx])
              entry_recency[i] <= entry_recency[i] + 1'b1;
          end
        end
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OccBits'(MAX_ENTRIES)) else $error("occupancy overflow");
  a_evict_put: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_evict |-> req_put && !found) else $error("bad eviction");
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == occupancy) else $error("occupancy mismatch");
endmodule
`default_nettype wire

// ===== rtl/lfu_cache_table_core.sv =====
// Top level of the LFU cache table with LRU tie-break.
//  channel | direction | signals
//  cfg     | in        | cfg_valid, cfg_ready, capacity
//  in      | in        | in_valid, in_ready, cmd, key, value
//  out     | out       | out_valid, out_ready, hit, read_value, evicted, evicted_key
// Each request steps through load, search over all entries, commit and result,
// then waits for the output, as the single search-then-update sequence sets.
// Reset clears valid bits, occupancy and capacity; no clearing pass.
// A stalled result holds the block; no new transfer is taken until it leaves.
`default_nettype none
module lfu_cache_table_core #(
  parameter int MAX_ENTRIES = lfuc_pkg::MaxEntries,
  parameter int KEY_BITS    = lfuc_pkg::KeyBits,
  parameter int DATA_BITS   = lfuc_pkg::DataBits,
  parameter int COUNT_BITS  = lfuc_pkg::CountBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  capacity,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit,
  output logic [31:0]      read_value,
  output logic             evicted,
  output logic [31:0]      evicted_key
);
  logic [lfuc_pkg::CapBits-1:0] cap_reg;
  lfuc_pkg::lfuc_cmd_t          dp_cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) cap_reg <= '0;
    else if (cfg_valid) cap_reg <= capacity;
  end

  lfuc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd(dp_cmd)
  );

  lfuc_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS),
    .DATA_BITS(DATA_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk, .rst, .cmd(dp_cmd), .capacity(cap_reg),
    .in_cmd(cmd), .in_key(key), .in_value(value),
    .hit, .read_value, .evicted, .evicted_key
  );
endmodule
`default_nettype wire

// ===== dv/lfu_cache_table_checker.sv =====
// Checker for the LFU cache table: tracks capacity writes, predicts results, compares.
`default_nettype none
module lfu_cache_table_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [4:0]  capacity,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        cmd,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        hit,
  input  wire logic [31:0] read_value,
  input  wire logic        evicted,
  input  wire logic [31:0] evicted_key,
  output int               failures,
  output int               pending
);
  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_result_t;

  lookup_result_t result_q[$];

  logic [4:0]  cap_reg;
  logic        slot_valid[lfuc_pkg::MaxEntries];
  logic [31:0] slot_key[lfuc_pkg::MaxEntries];
  logic [31:0] slot_data[lfuc_pkg::MaxEntries];
  logic [31:0] slot_uses[lfuc_pkg::MaxEntries];
  int          slot_age[lfuc_pkg::MaxEntries];
  int          fill;

  assign pending = result_q.size();

  // most recent gets age 0, younger entries age by one
  function automatic void refresh(input int i);
    for (int j = 0; j < lfuc_pkg::MaxEntries; j++)
      if (slot_valid[j] && j != i && slot_age[j] < slot_age[i]) slot_age[j]++;
    slot_age[i] = 0;
  endfunction

  function automatic void use_slot(input int i);
    if (slot_uses[i] != '1) slot_uses[i]++;
    refresh(i);
  endfunction

  function automatic lookup_result_t apply_request(input logic c, input logic [31:0] k,
                                                   input logic [31:0] v);
    lookup_result_t r;
    int found;
    int slot;
    int lim;
    r = '{hit: 1'b0, read_value: '1, evicted: 1'b0, evicted_key: '0};
    found = -1;
    slot = -1;
    lim = (cap_reg > lfuc_pkg::MaxEntries) ? lfuc_pkg::MaxEntries : cap_reg;
    for (int i = 0; i < lfuc_pkg::MaxEntries; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == k) found = i;
    r.hit = (found >= 0);
    if (c == lfuc_pkg::CMD_GET) begin
      if (found >= 0) begin
        r.read_value = slot_data[found];
        use_slot(found);
      end
    end else if (lim > 0) begin
      if (found >= 0) begin
        slot_data[found] = v;
        use_slot(found);
      end else begin
        if (fill >= lim) begin
          for (int i = 0; i < lfuc_pkg::MaxEntries; i++) begin
            if (slot_valid[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
                (slot_uses[i] == slot_uses[slot] && slot_age[i] > slot_age[slot])))
              slot = i;
          end
          if (slot >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = slot_key[slot];
            slot_valid[slot] = 1'b0;
            for (int i = 0; i < lfuc_pkg::MaxEntries; i++)
              if (slot_valid[i] && slot_age[i] > slot_age[slot]) slot_age[i]--;
            fill--;
          end
        end
        if (slot < 0)
          for (int i = lfuc_pkg::MaxEntries - 1; i >= 0; i--)
            if (!slot_valid[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < lfuc_pkg::MaxEntries; i++)
            if (slot_valid[i]) slot_age[i]++;
          slot_valid[slot] = 1'b1;
          slot_key[slot] = k;
          slot_data[slot] = v;
          slot_uses[slot] = 1;
          slot_age[slot] = 0;
          fill++;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    failures++;
  endtask

  initial failures = 0;

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      cap_reg <= '0;
      fill = 0;
      for (int i = 0; i < lfuc_pkg::MaxEntries; i++) begin
        slot_valid[i] = 1'b0;
        slot_age[i] = 0;
      end
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg <= capacity;
      if (in_valid && in_ready) result_q.push_back(apply_request(cmd, key, value));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", {31'b0, hit}, '0);
        end else begin
          want = result_q.pop_front();
          if (hit !== want.hit) report_mismatch("hit", {31'b0, hit}, {31'b0, want.hit});
          if (read_value !== want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
          if (evicted !== want.evicted)
            report_mismatch("evicted", {31'b0, evicted}, {31'b0, want.evicted});
          if (evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", evicted_key, want.evicted_key);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== dv/lfu_cache_table_core_tb.sv =====
// Testbench top for the LFU cache table: stimulus, capacity phases and verdict.
`default_nettype none
module lfu_cache_table_core_tb;
  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  capacity;
  logic        in_valid;
  logic        in_ready;
  logic        cmd;
  logic [31:0] key;
  logic [31:0] value;
  logic        out_valid;
  logic        out_ready;
  logic        hit;
  logic [31:0] read_value;
  logic        evicted;
  logic [31:0] evicted_key;
  int          failures;
  int          pending;
  logic        stimulus_done;
  logic        hold_off;

  logic [31:0] key_pool[8];

  lfu_cache_table_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .read_value(read_value),
    .evicted(evicted), .evicted_key(evicted_key)
  );

  lfu_cache_table_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .read_value(read_value),
    .evicted(evicted), .evicted_key(evicted_key),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] c);
    cfg_valid <= 1'b1;
    capacity <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // leaves valid high after the transfer; the next call drops it only before a gap, and drain() drops it
  task automatic send_request(input logic c, input logic [31:0] k, input logic [31:0] v);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      idle_cycles(n);
    end
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    idle_cycles(8);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic random_phase(input int n, input int idle_free);
    for (int i = 0; i < n; i++) begin
      if (idle_free != 0) begin
        in_valid <= 1'b1;
        cmd <= 1'($urandom_range(0, 1));
        key <= pick_key();
        value <= $urandom();
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
      end else begin
        send_request(1'($urandom_range(0, 1)), pick_key(), $urandom());
      end
    end
  endtask

  // receiver: random gaps, plus one long hold while the sender keeps pushing
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        idle_cycles(60);
        hold_off = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        idle_cycles(1 + gap_len());
      end else begin
        out_ready <= 1'b1;
        idle_cycles($urandom_range(1, 8));
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    capacity = '0;
    in_valid = 1'b0;
    cmd = lfuc_pkg::CMD_GET;
    key = '0;
    value = '0;
    stimulus_done = 1'b0;
    hold_off = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // capacity zero: puts are dropped but still report the lookup
    send_request(lfuc_pkg::CMD_PUT, 32'h0, 32'h1);
    send_request(lfuc_pkg::CMD_GET, 32'h0, 32'h0);
    drain();
    write_capacity(5'd2);
    send_request(lfuc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lfuc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lfuc_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(lfuc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0);
    send_request(lfuc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(lfuc_pkg::CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(lfuc_pkg::CMD_PUT, 32'h1234_5678, 32'h5555_AAAA);
    send_request(lfuc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
    drain();
    // lower capacity below occupancy, then zero: reads still hit
    write_capacity(5'd1);
    send_request(lfuc_pkg::CMD_PUT, 32'hAAAA_5555, 32'h1);
    send_request(lfuc_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    drain();
    write_capacity(5'd0);
    send_request(lfuc_pkg::CMD_PUT, 32'h0BAD_F00D, 32'h2);
    send_request(lfuc_pkg::CMD_GET, 32'hAAAA_5555, 32'h0);
    drain();
    // capacity above the table size clamps
    write_capacity(5'd31);

    foreach (key_pool[i]) key_pool[i] = $urandom();
    hold_off = 1'b1;
    random_phase(100, 1);
    drain();
    write_capacity(5'd16);
    for (int i = 0; i < 8; i++) key_pool[i] = (i < 4) ? $urandom() : $urandom_range(0, 20);
    random_phase(300, 0);
    drain();
    write_capacity(5'd3);
    random_phase(300, 0);
    drain();
    write_capacity(5'd1);
    random_phase(150, 1);
    drain();
    write_capacity(5'd0);
    random_phase(50, 0);
    drain();
    write_capacity(5'd7);
    random_phase(200, 0);
    drain();
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    while (pending != 0) @(negedge clk);
    idle_cycles(20);
    if (failures == 0)
      $display("lfu_cache_table_core verification clean");
    else
      $display("lfu_cache_table_core verification failed");
    $finish;
  end

  initial begin
    #10000000;
    $display("lfu_cache_table_core verification failed");
    $finish;
  end
endmodule
`default_nettype wire
